### hdl/hxc_pkg.sv
// Shared types, character codes and digit helpers for the hex text token converter.
// No dependencies; used by every module of the block by scoped names.
`default_nettype none

package hxc_pkg;

    localparam logic [7:0] CHAR_NL     = 8'd10;
    localparam logic [7:0] CHAR_SP     = 8'd32;
    localparam logic [7:0] CHAR_ZERO   = 8'd48;
    localparam logic [7:0] CHAR_SLASH  = 8'd47;
    localparam logic [7:0] CHAR_UP_A   = 8'd65;
    localparam logic [7:0] CHAR_UP_F   = 8'd70;
    localparam logic [7:0] CHAR_LOW_A  = 8'd97;
    localparam logic [7:0] CHAR_LOW_N  = 8'd110;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [1:0] TOKEN_LEN_ENCODE = 2'd1;
    localparam logic [1:0] TOKEN_LEN_DECODE = 2'd2;

    // One queued request: up to four result bytes, all error text or none.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            err;
    } cmd_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10)
            r = CHAR_ZERO + {4'd0, v};
        else
            r = CHAR_UP_A + {4'd0, v} - 8'd10;
        return r;
    endfunction

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] r;
        if (c >= CHAR_UP_A && c <= CHAR_UP_F)
            r = c - CHAR_UP_A + 8'd10;
        else
            r = c - CHAR_ZERO;
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/hxc_front.sv
// Front end: accepts input bytes, tracks token and line state, builds result requests.
// Depends on hxc_pkg.
`default_nettype none

module hxc_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         mode,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   in_byte,
    input  wire logic         q_full,
    output logic              push,
    output hxc_pkg::cmd_t     push_cmd
);

    logic [7:0] held_reg, held_next;
    logic [7:0] older_reg, older_next;
    logic [1:0] len_reg, len_next;
    logic       emitted_reg, emitted_next;
    logic       discard_reg, discard_next;

    logic       accept;
    logic [2:0] n;
    logic [7:0] dec_val;
    logic [7:0] dig_hi;
    logic [7:0] dig_lo;
    logic [1:0] limit;
    hxc_pkg::cmd_t cmd;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign dig_hi  = hxc_pkg::digit_value(older_reg);
    assign dig_lo  = hxc_pkg::digit_value(held_reg);
    assign dec_val = {dig_hi[3:0], 4'd0} + dig_lo;
    assign limit   = (mode == hxc_pkg::MODE_ENCODE) ? hxc_pkg::TOKEN_LEN_ENCODE
                                                    : hxc_pkg::TOKEN_LEN_DECODE;

    always_comb
    begin
        held_next    = held_reg;
        older_next   = older_reg;
        len_next     = len_reg;
        emitted_next = emitted_reg;
        discard_next = discard_reg;
        n            = 3'd0;
        cmd          = '0;

        if (discard_reg)
        begin
            if (in_byte == hxc_pkg::CHAR_NL)
            begin
                discard_next = 1'b0;
                held_next    = '0;
                older_next   = '0;
                len_next     = '0;
                emitted_next = 1'b0;
            end
        end
        else if (in_byte == hxc_pkg::CHAR_SP || in_byte == hxc_pkg::CHAR_NL)
        begin
            // close the current token
            if (mode == hxc_pkg::MODE_ENCODE && len_reg != 2'd0)
            begin
                if (emitted_reg)
                begin
                    cmd.bytes[n[1:0]] = hxc_pkg::CHAR_SP;
                    n = n + 3'd1;
                end
                cmd.bytes[n[1:0]] = hxc_pkg::hex_digit(held_reg[7:4]);
                n = n + 3'd1;
                cmd.bytes[n[1:0]] = hxc_pkg::hex_digit(held_reg[3:0]);
                n = n + 3'd1;
                emitted_next = 1'b1;
            end
            else if (mode == hxc_pkg::MODE_DECODE && len_reg == hxc_pkg::TOKEN_LEN_DECODE)
            begin
                if (emitted_reg)
                begin
                    cmd.bytes[n[1:0]] = hxc_pkg::CHAR_SP;
                    n = n + 3'd1;
                end
                cmd.bytes[n[1:0]] = dec_val;
                n = n + 3'd1;
                emitted_next = 1'b1;
            end
            len_next = '0;
            if (in_byte == hxc_pkg::CHAR_NL)
            begin
                cmd.bytes[n[1:0]] = hxc_pkg::CHAR_NL;
                n = n + 3'd1;
                held_next    = '0;
                older_next   = '0;
                emitted_next = 1'b0;
            end
        end
        else if (len_reg >= limit)
        begin
            // token too long: error text, then skip to end of line
            cmd.bytes[0] = hxc_pkg::CHAR_LOW_N;
            cmd.bytes[1] = hxc_pkg::CHAR_SLASH;
            cmd.bytes[2] = hxc_pkg::CHAR_LOW_A;
            cmd.bytes[3] = hxc_pkg::CHAR_NL;
            cmd.err      = 1'b1;
            n            = 3'd4;
            held_next    = '0;
            older_next   = '0;
            len_next     = '0;
            emitted_next = 1'b0;
            discard_next = 1'b1;
        end
        else
        begin
            older_next = held_reg;
            held_next  = in_byte;
            len_next   = len_reg + 2'd1;
        end

        cmd.last_idx = n[1:0] - 2'd1;
    end

    assign push     = accept && (n != 3'd0);
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            older_reg   <= '0;
            len_reg     <= '0;
            emitted_reg <= 1'b0;
            discard_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_reg    <= held_next;
            older_reg   <= older_next;
            len_reg     <= len_next;
            emitted_reg <= emitted_next;
            discard_reg <= discard_next;
        end
    end

endmodule

`default_nettype wire

### hdl/hxc_queue.sv
// Short request queue between front and back end, register based.
// Depends on hxc_pkg for the request type.
`default_nettype none

module hxc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire hxc_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output hxc_pkg::cmd_t      head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    hxc_pkg::cmd_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == CNT_FULL);
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = entry_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? ((wr_reg == PTR_LAST) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = pop  ? ((rd_reg == PTR_LAST) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head_valid))
        else $error("pop from empty queue");

    a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

`default_nettype wire

### hdl/hxc_back.sv
// Back end: walks the head request byte by byte into a registered output stage.
// Depends on hxc_pkg for the request type.
`default_nettype none

module hxc_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire hxc_pkg::cmd_t head_cmd,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               is_error,
    output logic               last
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       err_reg;
    logic       last_reg;
    logic       load;
    logic       at_end;

    assign load   = head_valid && (!valid_reg || out_ready);
    assign at_end = (idx_reg == head_cmd.last_idx);
    assign pop    = load && at_end;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = at_end ? 2'd0 : idx_reg + 2'd1;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head_cmd.bytes[idx_reg];
            err_reg  <= head_cmd.err;
            last_reg <= at_end;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign is_error  = err_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

### hdl/hex_text_token_converter.sv
// Path: the first result byte of an input is written into a queue entry and then loaded
// into the registered output stage, when the queue and the output stage are free.
// Throughput: one input byte per cycle while the queue is not full; the back end sends one
// result byte per cycle while out_ready is high, and an input gives at most four results.
// Reset (rst_n low, asynchronous): mode encode, line state cleared, queue empty.
// Depends on hxc_pkg, hxc_front, hxc_queue and hxc_back.
`default_nettype none

module hex_text_token_converter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input byte stream
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    // result stream
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             is_error,
    output logic             last,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Mode register lives at word 0; higher words are unmapped.
    logic mode_reg, mode_next;
    logic cfg_write;
    logic sel_mode;

    assign pready    = 1'b1;
    assign sel_mode  = (paddr[2] == 1'b0);
    assign cfg_write = psel && penable && pwrite && pready;
    assign mode_next = (cfg_write && sel_mode) ? pwdata[0] : mode_reg;
    assign prdata    = sel_mode ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= hxc_pkg::MODE_ENCODE;
        else
            mode_reg <= mode_next;
    end

    // Front end classifies each byte and hands a whole result request to the queue.
    logic          q_full;
    logic          push;
    hxc_pkg::cmd_t push_cmd;
    logic          pop;
    logic          head_valid;
    hxc_pkg::cmd_t head_cmd;

    hxc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Queue decouples the input side from output stalls.
    hxc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back end serializes each request onto the registered output.
    hxc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .is_error   (is_error),
        .last       (last)
    );

endmodule

`default_nettype wire
